// ===== rtl/double_ended_queue_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the double-ended queue unit
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH

// Property that must hold at every clock edge
`define DEQ_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define DEQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg
// Shared constants, operation and status codes, and cell link types.
// ----------------------------------------------------------------------------
package deq_pkg;

	localparam int DEPTH    = 16;
	localparam int DATA_W   = 32;
	localparam int FUNC_W   = 2;
	localparam int STATUS_W = 2;

	// Request operation codes
	typedef enum logic [FUNC_W-1:0] {
		FN_PUSH_BACK  = 2'd0,
		FN_POP_BACK   = 2'd1,
		FN_PUSH_FRONT = 2'd2,
		FN_POP_FRONT  = 2'd3
	} func_t;

	// Response status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// What one cell shows to its neighbours
	typedef struct packed {
		logic                     occ;
		logic signed [DATA_W-1:0] data;
	} link_t;

	// Row-wide command, one bit per effective operation
	typedef struct packed {
		logic push_front;
		logic pop_front;
		logic push_back;
		logic pop_back;
	} op_t;

endpackage

// ===== rtl/deq_if.sv =====
// ----------------------------------------------------------------------------
// Request and response channels
// Valid/ready channels; a transaction completes when both are high.
// ----------------------------------------------------------------------------
interface deq_req_if;
	logic                             valid;
	logic                             ready;
	logic [deq_pkg::FUNC_W-1:0]       func;
	logic signed [deq_pkg::DATA_W-1:0] data_value;

	modport source (output valid, func, data_value, input ready);
	modport sink   (input valid, func, data_value, output ready);
endinterface

interface deq_rsp_if;
	logic                             valid;
	logic                             ready;
	logic signed [deq_pkg::DATA_W-1:0] popped_value;
	logic [deq_pkg::STATUS_W-1:0]     status;

	modport source (output valid, popped_value, status, input ready);
	modport sink   (input valid, popped_value, status, output ready);
endinterface

// ===== rtl/deq_cell.sv =====
// ----------------------------------------------------------------------------
// deq_cell
// One slot of the queue row. Shifts with its neighbours on front operations,
// fills itself as the first free slot and empties itself as the back slot.
// ----------------------------------------------------------------------------
module deq_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  deq_pkg::op_t                      op,
	input  logic signed [deq_pkg::DATA_W-1:0] push_value,
	input  deq_pkg::link_t                    left,
	input  deq_pkg::link_t                    right,
	output deq_pkg::link_t                    held,
	output logic                              is_back
);

	logic                              occ_q;
	logic signed [deq_pkg::DATA_W-1:0] data_q;

	assign held    = '{occ: occ_q, data: data_q};
	// last occupied slot of the row
	assign is_back = occ_q && !right.occ;

	// occupancy, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (op.push_front) begin
			occ_q <= left.occ;
		end else if (op.pop_front) begin
			occ_q <= right.occ;
		end else if (op.push_back && left.occ && !occ_q) begin
			occ_q <= 1'b1;
		end else if (op.pop_back && is_back) begin
			occ_q <= 1'b0;
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (op.push_front) begin
			data_q <= left.data;
		end else if (op.pop_front) begin
			data_q <= right.data;
		end else if (op.push_back && left.occ && !occ_q) begin
			data_q <= push_value;
		end
	end

endmodule

// ===== rtl/double_ended_queue_unit.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded double-ended queue of signed 32-bit values built as a row of cells.
// ----------------------------------------------------------------------------
// Takes one request per clock cycle (push or pop at either end) and returns
// exactly one response per request from an output register loaded on accept;
// a new request is taken whenever that register is empty or being read in the
// same cycle, so the rate is one transaction per cycle unless the response side
// stalls. The entries sit in a row of DEPTH cells, slot 0 holding the front;
// front operations shift the whole row by one slot, back pushes fill only the
// first free slot and back pops empty only the last occupied one, whose value
// is selected across the row. A pop on an empty queue answers with the empty
// status and a zero value, a push on a full queue with the full status;
// neither changes the contents. No clearing pass is needed after reset.

`include "double_ended_queue_unit_macros.svh"

module double_ended_queue_unit (
	input  logic          clk,
	input  logic          arst_n,
	deq_req_if.sink       req,
	deq_rsp_if.source     rsp
);

	localparam int DEPTH = deq_pkg::DEPTH;

	deq_pkg::link_t                    cell_lnk  [DEPTH];
	deq_pkg::link_t                    left_lnk  [DEPTH];
	deq_pkg::link_t                    right_lnk [DEPTH];
	logic [DEPTH-1:0]                  back_vec;
	logic [DEPTH-1:0]                  occ_vec;
	logic signed [deq_pkg::DATA_W-1:0] back_data;

	deq_pkg::op_t                      op;
	deq_pkg::func_t                    fn;
	deq_pkg::status_t                  status_d;
	logic signed [deq_pkg::DATA_W-1:0] popped_d;
	logic                              req_fire;
	logic                              is_empty;
	logic                              is_full;

	logic                              rsp_valid_q;
	deq_pkg::status_t                  rsp_status_q;
	logic signed [deq_pkg::DATA_W-1:0] rsp_value_q;

	// handshake
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign req_fire  = req.valid && req.ready;
	assign fn        = deq_pkg::func_t'(req.func);

	assign is_empty  = !cell_lnk[0].occ;
	assign is_full   = cell_lnk[DEPTH-1].occ;

	// back slot value, one-hot select across the row
	always_comb begin
		back_data = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (back_vec[i]) begin
				back_data = back_data | cell_lnk[i].data;
			end
		end
	end

	// decode request into row command and response
	always_comb begin
		op       = '0;
		status_d = deq_pkg::ST_DONE;
		popped_d = '0;
		case (fn)
			deq_pkg::FN_PUSH_BACK: begin
				if (is_full) status_d = deq_pkg::ST_FULL;
				else         op.push_back = req_fire;
			end
			deq_pkg::FN_POP_BACK: begin
				if (is_empty) begin
					status_d = deq_pkg::ST_EMPTY;
				end else begin
					op.pop_back = req_fire;
					popped_d    = back_data;
				end
			end
			deq_pkg::FN_PUSH_FRONT: begin
				if (is_full) status_d = deq_pkg::ST_FULL;
				else         op.push_front = req_fire;
			end
			deq_pkg::FN_POP_FRONT: begin
				if (is_empty) begin
					status_d = deq_pkg::ST_EMPTY;
				end else begin
					op.pop_front = req_fire;
					popped_d     = cell_lnk[0].data;
				end
			end
			default: begin
				status_d = deq_pkg::ST_DONE;
			end
		endcase
	end

	// row of cells; slot 0 sees the incoming value as an occupied neighbour
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign left_lnk[i] = '{occ: 1'b1, data: req.data_value};
		end else begin : g_mid
			assign left_lnk[i] = cell_lnk[i-1];
		end
		if (i == DEPTH-1) begin : g_last
			assign right_lnk[i] = '0;
		end else begin : g_inner
			assign right_lnk[i] = cell_lnk[i+1];
		end

		deq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.op         (op),
			.push_value (req.data_value),
			.left       (left_lnk[i]),
			.right      (right_lnk[i]),
			.held       (cell_lnk[i]),
			.is_back    (back_vec[i])
		);

		assign occ_vec[i] = cell_lnk[i].occ;
	end

	// response register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (req_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// response register payload
	always_ff @(posedge clk) begin
		if (req_fire) begin
			rsp_status_q <= status_d;
			rsp_value_q  <= popped_d;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.popped_value = rsp_value_q;

	// checks
	`DEQ_ASSERT_ALWAYS(a_occ_contiguous, (occ_vec[DEPTH-1:1] & ~occ_vec[DEPTH-2:0]) == '0, "occupied slots not contiguous from the front")
	`DEQ_ASSERT_NEXT(a_push_grows, req_fire && (op.push_back || op.push_front), $countones(occ_vec) == $past($countones(occ_vec)) + 1, "accepted push did not add one entry")
	`DEQ_ASSERT_NEXT(a_pop_shrinks, req_fire && (op.pop_back || op.pop_front), $countones(occ_vec) + 1 == $past($countones(occ_vec)), "accepted pop did not remove one entry")
	`DEQ_ASSERT_ALWAYS(a_refused_zero, !rsp_valid_q || rsp_status_q == deq_pkg::ST_DONE || rsp_value_q == '0, "refused transaction carries a non-zero value")

endmodule
